FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the display formatter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define FDSF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FDSF_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/fdsf_pkg.sv
// ----------------------------------------------------------------------------
// Display formatter package
// Types, codes and the glyph table shared by the formatter modules.
// ----------------------------------------------------------------------------
package fdsf_pkg;

  localparam int DEFAULT_NUM_DIGITS = 4;
  localparam int MAX_DIGITS         = 8;
  localparam int OUT_DIGITS         = 4;
  localparam int NUM_W              = 16;
  localparam int DEC_STAGES         = 5;
  localparam int QUEUE_DEPTH        = 8;
  localparam int QUEUE_AW           = $clog2(QUEUE_DEPTH);
  localparam int POINT_IDX          = 7;

  typedef logic [7:0] seg_t;

  typedef enum logic [1:0] {
    REQ_NUMBER,
    REQ_GLYPH,
    REQ_POINT,
    REQ_ERROR
  } req_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_HEX,
    RADIX_OCT,
    RADIX_BIN
  } radix_t;

  typedef enum logic [2:0] {
    FAULT_NONE,
    FAULT_GLYPH,
    FAULT_POSITION,
    FAULT_POINT,
    FAULT_OVERFLOW
  } fault_t;

  localparam logic [4:0] GLYPH_ZERO    = 5'd0;
  localparam logic [4:0] GLYPH_E       = 5'd14;
  localparam logic [4:0] GLYPH_R       = 5'd16;
  localparam logic [7:0] GLYPH_BLANK   = 8'hFF;
  localparam logic [2:0] ERR_SHOW_ZERO = 3'd5;

  typedef struct packed {
    logic [MAX_DIGITS-1:0]       wmask;
    logic [MAX_DIGITS-1:0][7:0]  pat;
    logic [MAX_DIGITS-1:0]       set_mask;
    logic [MAX_DIGITS-1:0]       clr_mask;
    fault_t                      fault;
  } cmd_t;

  function automatic seg_t seg_pattern(input logic [4:0] code);
    seg_t p;
    unique case (code)
      5'd0:    p = 8'h3F;
      5'd1:    p = 8'h06;
      5'd2:    p = 8'h5B;
      5'd3:    p = 8'h4F;
      5'd4:    p = 8'h66;
      5'd5:    p = 8'h6D;
      5'd6:    p = 8'h7D;
      5'd7:    p = 8'h07;
      5'd8:    p = 8'h7F;
      5'd9:    p = 8'h6F;
      5'd10:   p = 8'h77;
      5'd11:   p = 8'h7C;
      5'd12:   p = 8'h58;
      5'd13:   p = 8'h5E;
      5'd14:   p = 8'h79;
      5'd15:   p = 8'h71;
      5'd16:   p = 8'h50;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/four_digit_seven_segment_formatter.sv
// ----------------------------------------------------------------------------
// Four-digit seven-segment formatter
// Keeps a seven-segment display image and updates it from number, glyph,
// decimal point and error commands, reporting the image after each one.
//
//   Channel  Handshake          Carries
//   in       in_valid/in_stall   one display command per transaction
//   out      out_valid/out_stall four digit images and fault code
//
// Sustained rate is one transaction per cycle while out_stall is low; a command
// passes through the input register and the four divide-by-ten stages of the
// digit split, then the queue and the output register.
// Reset clears the pipeline, the queue, the credit count and blanks the image.
// A stalled output holds its register; the pipeline and queue together hold
// up to eight transactions before in_stall rises.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_formatter import fdsf_pkg::*; #(
  parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_number,
  input  logic [1:0]  in_radix,
  input  logic [2:0]  in_position,
  input  logic [7:0]  in_glyph,
  input  logic [3:0]  in_dot_select,
  input  logic [2:0]  in_shown_error,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_digit1_segments,
  output logic [7:0]  out_digit2_segments,
  output logic [7:0]  out_digit3_segments,
  output logic [7:0]  out_digit4_segments,
  output logic [2:0]  out_fault_code
);

  logic                       push;
  cmd_t                       push_cmd;
  logic                       pop;
  logic                       q_valid;
  cmd_t                       q_cmd;
  logic [OUT_DIGITS-1:0][7:0] digits;

  fdsf_front #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_number      (in_number),
    .in_radix       (in_radix),
    .in_position    (in_position),
    .in_glyph       (in_glyph),
    .in_dot_select  (in_dot_select),
    .in_shown_error (in_shown_error),
    .credit_return  (pop),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  fdsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .not_empty (q_valid),
    .head_cmd  (q_cmd)
  );

  fdsf_back #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_digits (digits),
    .out_fault  (out_fault_code)
  );

  assign out_digit1_segments = digits[0];
  assign out_digit2_segments = digits[1];
  assign out_digit3_segments = digits[2];
  assign out_digit4_segments = digits[3];

endmodule

FILE: rtl/fdsf_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO of decoded display commands between the front and back ends.
// ----------------------------------------------------------------------------
module fdsf_queue import fdsf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic not_empty,
  output cmd_t head_cmd
);

  cmd_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;

  assign not_empty = (count_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/fdsf_front.sv
// ----------------------------------------------------------------------------
// Command front end
// Accepts requests, splits the number into digits over a divide-by-ten
// pipeline and decodes each request into per-digit write and point masks.
// ----------------------------------------------------------------------------
module fdsf_front import fdsf_pkg::*; #(
  parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_number,
  input  logic [1:0]  in_radix,
  input  logic [2:0]  in_position,
  input  logic [7:0]  in_glyph,
  input  logic [3:0]  in_dot_select,
  input  logic [2:0]  in_shown_error,
  input  logic        credit_return,
  output logic        push,
  output cmd_t        push_cmd
);

  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int LAST     = DEC_STAGES - 1;
  localparam int NUM_SPAN = 1 << NUM_W;

  function automatic int pow_cap(input int base, input int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * base;
      if (r > NUM_SPAN) begin
        r = NUM_SPAN;
      end
    end
    return r;
  endfunction

  localparam logic [NUM_W:0] LIMIT_DEC = (NUM_W+1)'(pow_cap(10, NUM_DIGITS));
  localparam logic [NUM_W:0] LIMIT_HEX = (NUM_W+1)'(pow_cap(16, NUM_DIGITS));
  localparam logic [NUM_W:0] LIMIT_OCT = (NUM_W+1)'(pow_cap(8, NUM_DIGITS));
  localparam logic [NUM_W:0] LIMIT_BIN = (NUM_W+1)'(pow_cap(2, NUM_DIGITS));

  typedef struct packed {
    req_t       req;
    radix_t     radix;
    logic [2:0] position;
    logic [7:0] glyph;
    logic [3:0] dot_select;
    logic [2:0] shown_error;
  } fld_t;

  function automatic logic [NUM_W-1:0] div10(input logic [NUM_W-1:0] x);
    logic [2*NUM_W-1:0] p;
    p = (2*NUM_W)'(x) * (2*NUM_W)'(52429);
    return NUM_W'(p[2*NUM_W-1:19]);
  endfunction

  function automatic cmd_t err_cmd(input logic [2:0] code);
    cmd_t c;
    c = '0;
    for (int a = 0; a < NUM_DIGITS; a++) begin
      if (a == 0) begin
        c.wmask[a] = 1'b1;
        c.pat[a]   = seg_pattern(GLYPH_E);
      end else if (a == 1 || a == 2) begin
        c.wmask[a] = 1'b1;
        c.pat[a]   = seg_pattern(GLYPH_R);
      end
      if (a == NUM_DIGITS - 1) begin
        if (code >= 3'd1 && code <= 3'd4) begin
          c.wmask[a] = 1'b1;
          c.pat[a]   = seg_pattern({2'b00, code});
        end else if (code == ERR_SHOW_ZERO) begin
          c.wmask[a] = 1'b1;
          c.pat[a]   = seg_pattern(GLYPH_ZERO);
        end
      end
    end
    return c;
  endfunction

  logic                  accept;
  logic [CNT_W-1:0]      used_r;
  logic [DEC_STAGES-1:0] vld_r;
  fld_t                  fld_r [DEC_STAGES];
  logic [NUM_W-1:0]      q_r   [DEC_STAGES][DEC_STAGES];

  assign in_stall = (used_r == CNT_W'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      vld_r  <= '0;
    end else begin
      used_r <= used_r + CNT_W'(accept) - CNT_W'(credit_return);
      vld_r  <= {vld_r[DEC_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    fld_r[0] <= '{req:         req_t'(in_req_type),
                  radix:       radix_t'(in_radix),
                  position:    in_position,
                  glyph:       in_glyph,
                  dot_select:  in_dot_select,
                  shown_error: in_shown_error};
    for (int k = 0; k < DEC_STAGES; k++) begin
      q_r[0][k] <= (k == 0) ? in_number : '0;
    end
  end

  for (genvar s = 1; s < DEC_STAGES; s++) begin : g_stage
    always_ff @(posedge clk) begin
      fld_r[s] <= fld_r[s-1];
      for (int k = 0; k < DEC_STAGES; k++) begin
        q_r[s][k] <= (k == s) ? div10(q_r[s-1][s-1]) : q_r[s-1][k];
      end
    end
  end

  always_comb begin
    fld_t             f;
    logic [NUM_W-1:0] num;
    logic [3:0]       dd [MAX_DIGITS];
    logic             ovf;
    logic             pos_ok;
    logic [4:0]       sel;
    logic [4:0]       code;
    logic             blank;
    seg_t             gpat;
    cmd_t             c;
    int               k;

    f   = fld_r[LAST];
    num = q_r[LAST][0];
    for (int i = 0; i < DEC_STAGES - 1; i++) begin
      dd[i] = 4'(q_r[LAST][i] - (q_r[LAST][i+1] << 3) - (q_r[LAST][i+1] << 1));
    end
    dd[DEC_STAGES-1] = 4'(q_r[LAST][DEC_STAGES-1]);
    for (int i = DEC_STAGES; i < MAX_DIGITS; i++) begin
      dd[i] = '0;
    end

    unique case (f.radix)
      RADIX_DEC: ovf = {1'b0, num} >= LIMIT_DEC;
      RADIX_HEX: ovf = {1'b0, num} >= LIMIT_HEX;
      RADIX_OCT: ovf = {1'b0, num} >= LIMIT_OCT;
      RADIX_BIN: ovf = {1'b0, num} >= LIMIT_BIN;
    endcase

    pos_ok = (f.position != 3'd0) && ({1'b0, f.position} <= 4'(NUM_DIGITS));
    sel    = {1'b0, f.dot_select};
    gpat   = (f.glyph == GLYPH_BLANK) ? 8'h00 : seg_pattern(f.glyph[4:0]);
    c      = '0;
    k      = 0;
    code   = '0;
    blank  = 1'b0;

    unique case (f.req)
      REQ_NUMBER: begin
        if (ovf) begin
          c       = err_cmd(3'(FAULT_OVERFLOW));
          c.fault = FAULT_OVERFLOW;
        end else begin
          for (int a = 0; a < NUM_DIGITS; a++) begin
            k = NUM_DIGITS - 1 - a;
            unique case (f.radix)
              RADIX_DEC: begin
                code  = {1'b0, dd[k]};
                blank = 1'b0;
              end
              RADIX_HEX: begin
                code  = 5'((32'(num) >> (4 * k)) & 32'hF);
                blank = (k > 0) && ((32'(num) >> (4 * k)) == 32'd0);
              end
              RADIX_OCT: begin
                code  = 5'((32'(num) >> (3 * k)) & 32'h7);
                blank = (k > 0) && ((32'(num) >> (3 * k)) == 32'd0);
              end
              RADIX_BIN: begin
                code  = 5'((32'(num) >> k) & 32'h1);
                blank = 1'b0;
              end
            endcase
            c.wmask[a] = 1'b1;
            c.pat[a]   = blank ? 8'h00 : seg_pattern(code);
          end
        end
      end
      REQ_GLYPH: begin
        priority if (!pos_ok) begin
          c       = err_cmd(3'(FAULT_POSITION));
          c.fault = FAULT_POSITION;
        end else if (f.glyph <= {3'b000, GLYPH_R} || f.glyph == GLYPH_BLANK) begin
          for (int a = 0; a < NUM_DIGITS; a++) begin
            if ({1'b0, f.position} == 4'(a + 1)) begin
              c.wmask[a] = 1'b1;
              c.pat[a]   = gpat;
            end
          end
        end else begin
          c       = err_cmd(3'(FAULT_GLYPH));
          c.fault = FAULT_GLYPH;
        end
      end
      REQ_POINT: begin
        if (sel == 5'd0 || sel > 5'(2 * NUM_DIGITS)) begin
          c       = err_cmd(3'(FAULT_POINT));
          c.fault = FAULT_POINT;
        end else begin
          for (int a = 0; a < NUM_DIGITS; a++) begin
            c.set_mask[a] = (sel == 5'(a + 1));
            c.clr_mask[a] = (sel == 5'(a + 1 + NUM_DIGITS));
          end
        end
      end
      REQ_ERROR: begin
        c = err_cmd(f.shown_error);
      end
    endcase

    push_cmd = c;
  end

  assign push = vld_r[LAST];

endmodule

FILE: rtl/fdsf_back.sv
// ----------------------------------------------------------------------------
// Display back end
// Applies decoded commands to the display image and holds the result
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module fdsf_back import fdsf_pkg::*; #(
  parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  cmd_t                       q_cmd,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [OUT_DIGITS-1:0][7:0] out_digits,
  output logic [2:0]                 out_fault
);

  seg_t       image_r   [NUM_DIGITS];
  seg_t       image_nxt [MAX_DIGITS];
  logic       out_valid_r;
  logic [OUT_DIGITS-1:0][7:0] digits_r;
  logic [2:0] fault_r;

  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    seg_t p;
    for (int a = 0; a < MAX_DIGITS; a++) begin
      image_nxt[a] = '0;
    end
    for (int a = 0; a < NUM_DIGITS; a++) begin
      p            = q_cmd.wmask[a] ? q_cmd.pat[a] : image_r[a];
      p[POINT_IDX] = (p[POINT_IDX] | q_cmd.set_mask[a]) & ~q_cmd.clr_mask[a];
      image_nxt[a] = p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int a = 0; a < NUM_DIGITS; a++) begin
        image_r[a] <= '0;
      end
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
      for (int a = 0; a < NUM_DIGITS; a++) begin
        image_r[a] <= image_nxt[a];
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int j = 0; j < OUT_DIGITS; j++) begin
        digits_r[j] <= image_nxt[j];
      end
      fault_r <= 3'(q_cmd.fault);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_digits = digits_r;
  assign out_fault  = fault_r;

endmodule

FILE: rtl/fdsf_checker.sv
// ----------------------------------------------------------------------------
// Formatter port checker
// Concurrent checks on the formatter ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdsf_checker import fdsf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_digit1_segments,
  input logic [7:0] out_digit2_segments,
  input logic [7:0] out_digit3_segments,
  input logic [7:0] out_digit4_segments,
  input logic [2:0] out_fault_code
);

  localparam seg_t SEG_E = seg_pattern(GLYPH_E);

  logic [34:0] out_word;
  logic        fault_set;
  logic        err_shown;

  assign out_word  = {out_digit1_segments, out_digit2_segments, out_digit3_segments,
                      out_digit4_segments, out_fault_code};
  assign fault_set = out_valid && (out_fault_code != 3'(FAULT_NONE));
  assign err_shown = (out_digit1_segments == SEG_E);

  `FDSF_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled result changed")
  `FDSF_ASSERT(a_fault_image, clk, rst_n, fault_set |-> err_shown, "fault without error image")
  `FDSF_ASSERT_NORST(a_rst_out, clk, !rst_n |=> !out_valid, "result valid after reset")
  `FDSF_ASSERT_NORST(a_rst_in, clk, !rst_n |=> !in_stall, "input stalled after reset")

endmodule

bind four_digit_seven_segment_formatter fdsf_checker u_fdsf_checker (.*);

FILE: dv/fdsf_image_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Display image checker
// Watches both channels of the seven-segment formatter. It keeps its own copy
// of the four-digit image, updates it for every accepted command transaction
// and compares each accepted result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module fdsf_image_checker import fdsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_number,
  input  logic [1:0]  in_radix,
  input  logic [2:0]  in_position,
  input  logic [7:0]  in_glyph,
  input  logic [3:0]  in_dot_select,
  input  logic [2:0]  in_shown_error,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_digit1_segments,
  input  logic [7:0]  out_digit2_segments,
  input  logic [7:0]  out_digit3_segments,
  input  logic [7:0]  out_digit4_segments,
  input  logic [2:0]  out_fault_code,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  localparam int DIGITS = DEFAULT_NUM_DIGITS;

  localparam seg_t GLYPH_SEGMENTS [17] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71,
    8'h50
  };

  typedef struct {
    seg_t   digit [DIGITS];
    fault_t fault;
  } image_t;

  seg_t   shadow_image [DIGITS];
  image_t expected_images [$];
  image_t want;
  seg_t   got_digit [DIGITS];
  int     mismatches;
  int     results_seen;

  function automatic void paint_error(input logic [2:0] code);
    shadow_image[0] = GLYPH_SEGMENTS[GLYPH_E];
    shadow_image[1] = GLYPH_SEGMENTS[GLYPH_R];
    shadow_image[2] = GLYPH_SEGMENTS[GLYPH_R];
    if (code >= 3'd1 && code <= 3'd4) begin
      shadow_image[DIGITS-1] = GLYPH_SEGMENTS[code];
    end else if (code == ERR_SHOW_ZERO) begin
      shadow_image[DIGITS-1] = GLYPH_SEGMENTS[GLYPH_ZERO];
    end
  endfunction

  function automatic image_t apply_command(input req_t req, input logic [15:0] num,
                                           input radix_t rdx, input logic [2:0] pos,
                                           input logic [7:0] gl, input logic [3:0] ds,
                                           input logic [2:0] se);
    image_t      res;
    int unsigned base;
    int unsigned limit;
    int unsigned weight;
    int unsigned d;
    seg_t        pat;
    fault_t      f;
    f = FAULT_NONE;
    case (req)
      REQ_NUMBER: begin
        case (rdx)
          RADIX_DEC: base = 10;
          RADIX_HEX: base = 16;
          RADIX_OCT: base = 8;
          default:   base = 2;
        endcase
        limit = base * base * base * base;
        if (num >= limit) begin
          paint_error(FAULT_OVERFLOW);
          f = FAULT_OVERFLOW;
        end else begin
          weight = 1;
          for (int k = 0; k < DIGITS; k++) begin
            d = (num / weight) % base;
            pat = GLYPH_SEGMENTS[d];
            if ((rdx == RADIX_HEX || rdx == RADIX_OCT) && k > 0 && num < weight) begin
              pat = '0;
            end
            shadow_image[DIGITS-1-k] = pat;
            weight = weight * base;
          end
        end
      end
      REQ_GLYPH: begin
        if (pos < 1 || pos > DIGITS) begin
          paint_error(FAULT_POSITION);
          f = FAULT_POSITION;
        end else if (gl <= GLYPH_R) begin
          shadow_image[pos-1] = GLYPH_SEGMENTS[gl];
        end else if (gl == GLYPH_BLANK) begin
          shadow_image[pos-1] = '0;
        end else begin
          paint_error(FAULT_GLYPH);
          f = FAULT_GLYPH;
        end
      end
      REQ_POINT: begin
        if (ds >= 1 && ds <= DIGITS) begin
          shadow_image[ds-1][POINT_IDX] = 1'b1;
        end else if (ds > DIGITS && ds <= 2 * DIGITS) begin
          shadow_image[ds-1-DIGITS][POINT_IDX] = 1'b0;
        end else begin
          paint_error(FAULT_POINT);
          f = FAULT_POINT;
        end
      end
      default: begin
        paint_error(se);
      end
    endcase
    res.digit = shadow_image;
    res.fault = f;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_images.delete();
      foreach (shadow_image[k]) shadow_image[k] = '0;
      mismatches = 0;
      results_seen = 0;
      fail_count <= 0;
      pending <= 0;
      checked <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        got_digit[0] = out_digit1_segments;
        got_digit[1] = out_digit2_segments;
        got_digit[2] = out_digit3_segments;
        got_digit[3] = out_digit4_segments;
        if (expected_images.size() == 0) begin
          mismatches++;
          $display("%0t ns: result transaction with nothing expected, actual %h %h %h %h %0d",
                   $time, got_digit[0], got_digit[1], got_digit[2], got_digit[3],
                   out_fault_code);
        end else begin
          want = expected_images.pop_front();
          for (int k = 0; k < DIGITS; k++) begin
            if (got_digit[k] !== want.digit[k]) begin
              mismatches++;
              $display("%0t ns: digit%0d_segments expected %h, actual %h",
                       $time, k + 1, want.digit[k], got_digit[k]);
            end
          end
          if (out_fault_code !== want.fault) begin
            mismatches++;
            $display("%0t ns: fault_code expected %0d, actual %0d",
                     $time, want.fault, out_fault_code);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_images.push_back(apply_command(req_t'(in_req_type), in_number,
                                                radix_t'(in_radix), in_position,
                                                in_glyph, in_dot_select, in_shown_error));
      end
      fail_count <= mismatches;
      pending <= expected_images.size();
      checked <= results_seen;
    end
  end

endmodule

FILE: dv/tb_four_digit_seven_segment_formatter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seven-segment formatter testbench
// Drives directed and random display commands into the formatter with random
// gaps and output stalls, lets the image checker score every result and
// reports the verdict once all results have drained.
// ----------------------------------------------------------------------------
module tb_four_digit_seven_segment_formatter;
  import fdsf_pkg::*;

  localparam int RANDOM_COMMANDS = 1500;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [15:0] in_number;
  logic [1:0]  in_radix;
  logic [2:0]  in_position;
  logic [7:0]  in_glyph;
  logic [3:0]  in_dot_select;
  logic [2:0]  in_shown_error;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_digit1_segments;
  logic [7:0]  out_digit2_segments;
  logic [7:0]  out_digit3_segments;
  logic [7:0]  out_digit4_segments;
  logic [2:0]  out_fault_code;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int stall_left;
  int stall_draw;
  bit burst = 1'b0;

  always #6 clk = ~clk;

  four_digit_seven_segment_formatter uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_number           (in_number),
    .in_radix            (in_radix),
    .in_position         (in_position),
    .in_glyph            (in_glyph),
    .in_dot_select       (in_dot_select),
    .in_shown_error      (in_shown_error),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_digit1_segments (out_digit1_segments),
    .out_digit2_segments (out_digit2_segments),
    .out_digit3_segments (out_digit3_segments),
    .out_digit4_segments (out_digit4_segments),
    .out_fault_code      (out_fault_code)
  );

  fdsf_image_checker u_image_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_number           (in_number),
    .in_radix            (in_radix),
    .in_position         (in_position),
    .in_glyph            (in_glyph),
    .in_dot_select       (in_dot_select),
    .in_shown_error      (in_shown_error),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_digit1_segments (out_digit1_segments),
    .out_digit2_segments (out_digit2_segments),
    .out_digit3_segments (out_digit3_segments),
    .out_digit4_segments (out_digit4_segments),
    .out_fault_code      (out_fault_code),
    .fail_count          (fail_count),
    .pending             (pending),
    .checked             (checked)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_draw = burst ? 0 : $urandom_range(0, 5);
      stall_left <= stall_draw;
      out_stall <= (stall_draw != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  task automatic send_cmd(input req_t r, input logic [15:0] num, input radix_t rx,
                          input logic [2:0] pos, input logic [7:0] gl,
                          input logic [3:0] ds, input logic [2:0] se);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r;
    in_number <= num;
    in_radix <= rx;
    in_position <= pos;
    in_glyph <= gl;
    in_dot_select <= ds;
    in_shown_error <= se;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_random();
    radix_t      rx;
    logic [15:0] num;
    logic [2:0]  pos;
    logic [7:0]  gl;
    logic [3:0]  ds;
    rx = radix_t'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0, 1: num = 16'($urandom);
      2: num = 16'((32'd1 << $urandom_range(0, 16)) - $urandom_range(0, 1));
      3: num = 16'($urandom_range(9990, 10010));
      default: begin
        case (rx)
          RADIX_DEC: num = 16'($urandom_range(0, 9999));
          RADIX_HEX: num = 16'($urandom);
          RADIX_OCT: num = 16'($urandom_range(0, 4095));
          default:   num = 16'($urandom_range(0, 15));
        endcase
      end
    endcase
    pos = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0:       gl = GLYPH_BLANK;
      1, 2:    gl = 8'($urandom_range(0, 255));
      default: gl = 8'($urandom_range(0, 16));
    endcase
    ds = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
    send_cmd(req_t'($urandom_range(0, 3)), num, rx, pos, gl, ds, 3'($urandom_range(0, 7)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_number = '0;
    in_radix = '0;
    in_position = '0;
    in_glyph = '0;
    in_dot_select = '0;
    in_shown_error = '0;
    sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(REQ_NUMBER, 16'd0,      RADIX_DEC, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_NUMBER, 16'd9999,   RADIX_DEC, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_NUMBER, 16'd10000,  RADIX_DEC, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_NUMBER, 16'hFFFF,   RADIX_HEX, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_NUMBER, 16'h0000,   RADIX_HEX, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_NUMBER, 16'h0010,   RADIX_HEX, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_NUMBER, 16'o7777,   RADIX_OCT, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_NUMBER, 16'o10,     RADIX_OCT, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_NUMBER, 16'o100,    RADIX_OCT, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_NUMBER, 16'o1000,   RADIX_OCT, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_NUMBER, 16'o10000,  RADIX_OCT, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_NUMBER, 16'd15,     RADIX_BIN, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_NUMBER, 16'd16,     RADIX_BIN, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_GLYPH,  16'd0,      RADIX_DEC, 3'd1, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_GLYPH,  16'd0,      RADIX_DEC, 3'd4, 8'h10, 4'd0, 3'd0);
    send_cmd(REQ_GLYPH,  16'd0,      RADIX_DEC, 3'd2, 8'hFF, 4'd0, 3'd0);
    send_cmd(REQ_GLYPH,  16'd0,      RADIX_DEC, 3'd0, 8'h05, 4'd0, 3'd0);
    send_cmd(REQ_GLYPH,  16'd0,      RADIX_DEC, 3'd7, 8'h11, 4'd0, 3'd0);
    send_cmd(REQ_GLYPH,  16'd0,      RADIX_DEC, 3'd3, 8'h11, 4'd0, 3'd0);
    send_cmd(REQ_POINT,  16'd0,      RADIX_DEC, 3'd0, 8'h00, 4'd2, 3'd0);
    send_cmd(REQ_POINT,  16'd0,      RADIX_DEC, 3'd0, 8'h00, 4'd4, 3'd0);
    send_cmd(REQ_POINT,  16'd0,      RADIX_DEC, 3'd0, 8'h00, 4'd5, 3'd0);
    send_cmd(REQ_POINT,  16'd0,      RADIX_DEC, 3'd0, 8'h00, 4'd8, 3'd0);
    send_cmd(REQ_GLYPH,  16'd0,      RADIX_DEC, 3'd2, 8'h0A, 4'd0, 3'd0);
    send_cmd(REQ_POINT,  16'd0,      RADIX_DEC, 3'd0, 8'h00, 4'd0, 3'd0);
    send_cmd(REQ_POINT,  16'd0,      RADIX_DEC, 3'd0, 8'h00, 4'd15, 3'd0);
    send_cmd(REQ_ERROR,  16'd0,      RADIX_DEC, 3'd0, 8'h00, 4'd0, 3'd5);
    send_cmd(REQ_ERROR,  16'd0,      RADIX_DEC, 3'd0, 8'h00, 4'd0, 3'd0);
    drain();

    for (int i = 0; i < RANDOM_COMMANDS; i++) begin
      if ($urandom_range(0, 99) == 0) burst <= ~burst;
      if (i == RANDOM_COMMANDS / 2) drain();
      send_random();
    end
    drain();
    repeat (20) @(posedge clk);

    $display("Summary: %0d commands sent covering every command type, radix and fault code,",
             sent);
    $display("         with random gaps and stalls; %0d result transactions checked.", checked);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
